// File: rtl/gcfo_pkg.sv
// Shared types and constants for the floating-origin grid partition block.
// Holds the item structs, the controller state and command types.
// No dependencies.
package gcfo_pkg;

  // Field and register widths.
  localparam int unsigned PosW     = 40;
  localparam int unsigned CellW    = 32;
  localparam int unsigned CsW      = 25;
  localparam int unsigned HeW      = 39;
  localparam int unsigned RdW      = 31;
  localparam int unsigned CfgW     = 39;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned MulW     = 33;

  // One quotient bit per divider step, one step per dividend bit.
  localparam int unsigned DivSteps = PosW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Register reset values, also used in place of a zero register.
  localparam logic [CsW-1:0] CellSizeDefault = 25'd32768;
  localparam logic [HeW-1:0] HalfExtDefault  = 39'd512000;
  localparam logic [RdW-1:0] RebaseDefault   = 31'd131072;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgCellSize   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHalfExtent = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRebaseDist = 2'd2;

  // Item commands.
  localparam logic CmdLocate = 1'b0;
  localparam logic CmdFocus  = 1'b1;

  typedef struct packed {
    logic                   cmd;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_z;
  } gcfo_in_t;

  typedef struct packed {
    logic signed [CellW-1:0] cell_x;
    logic signed [CellW-1:0] cell_z;
    logic                    outside;
    logic signed [PosW-1:0]  corner_x;
    logic signed [PosW-1:0]  corner_z;
    logic signed [PosW-1:0]  local_x;
    logic signed [PosW-1:0]  local_y;
    logic signed [PosW-1:0]  local_z;
    logic                    rebased;
    logic signed [PosW-1:0]  origin_out_x;
    logic signed [PosW-1:0]  origin_out_y;
    logic signed [PosW-1:0]  origin_out_z;
  } gcfo_out_t;

  // Operand selection for the shared multiplier.
  typedef enum logic [2:0] {
    MUL_CX,
    MUL_CZ,
    MUL_AX,
    MUL_AZ,
    MUL_RD
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX,
    ST_MUL_CX,
    ST_MUL_CZ,
    ST_MUL_AX,
    ST_MUL_AZ,
    ST_MUL_RD,
    ST_DONE
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     div_step;
    logic     fix;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     commit;
  } dp_cmd_t;

endpackage

// File: rtl/gcfo_ctrl.sv
// Controller for the floating-origin grid partition block.
// Sequences load, divide, floor fix, multiplies and commit of one item.
// Depends on gcfo_pkg.
module gcfo_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output gcfo_pkg::dp_cmd_t cmd
);

  gcfo_pkg::ctl_state_t             state_r, state_nxt;
  logic [gcfo_pkg::DivCntW-1:0]     cnt_r, cnt_nxt;
  logic                             out_valid_r, out_valid_nxt;

  // State, step counter and output valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gcfo_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    cmd.mul_sel = gcfo_pkg::MUL_CX;
    unique case (state_r)
      gcfo_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = gcfo_pkg::ST_DIV;
        end
      end
      gcfo_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == gcfo_pkg::DivCntW'(gcfo_pkg::DivSteps - 1)) begin
          state_nxt = gcfo_pkg::ST_FIX;
        end
      end
      gcfo_pkg::ST_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = gcfo_pkg::ST_MUL_CX;
      end
      gcfo_pkg::ST_MUL_CX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = gcfo_pkg::MUL_CX;
        state_nxt   = gcfo_pkg::ST_MUL_CZ;
      end
      gcfo_pkg::ST_MUL_CZ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = gcfo_pkg::MUL_CZ;
        state_nxt   = gcfo_pkg::ST_MUL_AX;
      end
      gcfo_pkg::ST_MUL_AX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = gcfo_pkg::MUL_AX;
        state_nxt   = gcfo_pkg::ST_MUL_AZ;
      end
      gcfo_pkg::ST_MUL_AZ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = gcfo_pkg::MUL_AZ;
        state_nxt   = gcfo_pkg::ST_MUL_RD;
      end
      gcfo_pkg::ST_MUL_RD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = gcfo_pkg::MUL_RD;
        state_nxt   = gcfo_pkg::ST_DONE;
      end
      gcfo_pkg::ST_DONE: begin
        // Commit once the output register is free or being emptied.
        if (!(out_valid_r && out_stall)) begin
          cmd.commit = 1'b1;
          state_nxt  = gcfo_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gcfo_pkg::ST_IDLE;
      end
    endcase
  end

  // The output register stays full until its transfer completes.
  assign out_valid_nxt = cmd.commit | (out_valid_r & out_stall);

  assign in_stall  = (state_r != gcfo_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: rtl/gcfo_dpath.sv
// Datapath for the floating-origin grid partition block.
// Holds configuration, origin, two divider lanes, a shared multiplier and the
// output register. Depends on gcfo_pkg.
module gcfo_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [gcfo_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [gcfo_pkg::CfgW-1:0]       cfg_wdata,
  input  gcfo_pkg::gcfo_in_t              in_data,
  input  gcfo_pkg::dp_cmd_t               cmd,
  output gcfo_pkg::gcfo_out_t             out_data
);

  localparam int unsigned PosW  = gcfo_pkg::PosW;
  localparam int unsigned CellW = gcfo_pkg::CellW;
  localparam int unsigned CsW   = gcfo_pkg::CsW;
  localparam int unsigned MulW  = gcfo_pkg::MulW;

  // Saturate a 41-bit difference to 40 bits.
  function automatic logic [PosW-1:0] sat_diff(input logic [PosW:0] v);
    logic [PosW-1:0] res;
    if (v[PosW] != v[PosW-1]) begin
      res = v[PosW] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
    end else begin
      res = v[PosW-1:0];
    end
    return res;
  endfunction

  // Magnitude of a 41-bit difference.
  function automatic logic [PosW:0] mag_diff(input logic [PosW:0] v);
    return v[PosW] ? (~v + 1'b1) : v;
  endfunction

  // One restoring divide step: returns {remainder, shifted dividend/quotient}.
  function automatic logic [CsW+PosW-1:0] div_step(input logic [PosW-1:0] dvd,
                                                   input logic [CsW-1:0]  rem,
                                                   input logic [CsW-1:0]  dsr);
    logic [CsW:0]   trial;
    logic           ge;
    logic [CsW-1:0] rem_new;
    trial   = {rem, dvd[PosW-1]};
    ge      = (trial >= {1'b0, dsr});
    rem_new = ge ? CsW'(trial - {1'b0, dsr}) : trial[CsW-1:0];
    return {rem_new, dvd[PosW-2:0], ge};
  endfunction

  // Floor correction of a magnitude quotient, saturated to 32 bits.
  function automatic logic [CellW-1:0] floor_sat(input logic            neg,
                                                 input logic [PosW-1:0] q,
                                                 input logic            rnz);
    logic [PosW:0]    qm;
    logic [CellW-1:0] res;
    qm = {1'b0, q} + {{PosW{1'b0}}, rnz};
    if (!neg) begin
      res = (q > {{(PosW-CellW+1){1'b0}}, {(CellW-1){1'b1}}}) ?
            {1'b0, {(CellW-1){1'b1}}} : q[CellW-1:0];
    end else begin
      res = (qm > {{(PosW-CellW){1'b0}}, 1'b1, {(CellW-1){1'b0}}}) ?
            {1'b1, {(CellW-1){1'b0}}} : (~qm[CellW-1:0] + 1'b1);
    end
    return res;
  endfunction

  // Saturate a signed product to 40 bits.
  function automatic logic [PosW-1:0] sat_prod(input logic [2*MulW-1:0] p);
    logic [2*MulW-PosW:0] hi;
    logic [PosW-1:0]      res;
    hi = p[2*MulW-1:PosW-1];
    if ((&hi) || !(|hi)) begin
      res = p[PosW-1:0];
    end else begin
      res = p[2*MulW-1] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
    end
    return res;
  endfunction

  // Configuration registers.
  logic [CsW-1:0]           cell_size_r;
  logic [gcfo_pkg::HeW-1:0] half_extent_r;
  logic [gcfo_pkg::RdW-1:0] rebase_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r   <= gcfo_pkg::CellSizeDefault;
      half_extent_r <= gcfo_pkg::HalfExtDefault;
      rebase_dist_r <= gcfo_pkg::RebaseDefault;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gcfo_pkg::CfgCellSize:   cell_size_r   <= cfg_wdata[CsW-1:0];
        gcfo_pkg::CfgHalfExtent: half_extent_r <= cfg_wdata[gcfo_pkg::HeW-1:0];
        gcfo_pkg::CfgRebaseDist: rebase_dist_r <= cfg_wdata[gcfo_pkg::RdW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Origin state.
  logic [PosW-1:0] origin_x_r, origin_y_r, origin_z_r;

  // Per-item working registers.
  logic                     cmd_r;
  logic [PosW-1:0]          pos_y_r;
  logic [CsW-1:0]           cs_r;
  logic [gcfo_pkg::RdW-1:0] rd_r;
  logic                     outside_r;
  logic                     neg_x_r, neg_z_r;
  logic [PosW-1:0]          dvd_x_r, dvd_z_r;
  logic [CsW-1:0]           rem_x_r, rem_z_r;
  logic [PosW-1:0]          local_x_r, local_y_r, local_z_r;
  logic [31:0]              ax_r, az_r;
  logic                     big_r;
  logic [CellW-1:0]         cell_x_r, cell_z_r;
  logic [PosW-1:0]          corner_x_r, corner_z_r;
  logic [63:0]              sqx_r, sqz_r;
  logic [61:0]              thr2_r;
  gcfo_pkg::gcfo_out_t      out_r;

  // Load-time values: effective registers, magnitudes and offsets from origin.
  logic [CsW-1:0]           cs_eff;
  logic [gcfo_pkg::HeW-1:0] he_eff;
  logic [gcfo_pkg::RdW-1:0] rd_eff;
  logic [PosW-1:0]          px_u, py_u, pz_u, magx, magz;
  logic [PosW:0]            dx, dy, dz, adx, adz;

  always_comb begin
    cs_eff = (cell_size_r == '0)   ? gcfo_pkg::CellSizeDefault : cell_size_r;
    he_eff = (half_extent_r == '0) ? gcfo_pkg::HalfExtDefault  : half_extent_r;
    rd_eff = (rebase_dist_r == '0) ? gcfo_pkg::RebaseDefault   : rebase_dist_r;
    px_u   = in_data.pos_x;
    py_u   = in_data.pos_y;
    pz_u   = in_data.pos_z;
    magx   = px_u[PosW-1] ? (~px_u + 1'b1) : px_u;
    magz   = pz_u[PosW-1] ? (~pz_u + 1'b1) : pz_u;
    dx     = {px_u[PosW-1], px_u} - {origin_x_r[PosW-1], origin_x_r};
    dy     = {py_u[PosW-1], py_u} - {origin_y_r[PosW-1], origin_y_r};
    dz     = {pz_u[PosW-1], pz_u} - {origin_z_r[PosW-1], origin_z_r};
    adx    = mag_diff(dx);
    adz    = mag_diff(dz);
  end

  // Shared multiplier operand selection.
  logic signed [MulW-1:0]   opa, opb;
  logic signed [2*MulW-1:0] prod;

  always_comb begin
    opa = '0;
    opb = '0;
    unique case (cmd.mul_sel)
      gcfo_pkg::MUL_CX: begin
        opa = {cell_x_r[CellW-1], cell_x_r};
        opb = {{(MulW-CsW){1'b0}}, cs_r};
      end
      gcfo_pkg::MUL_CZ: begin
        opa = {cell_z_r[CellW-1], cell_z_r};
        opb = {{(MulW-CsW){1'b0}}, cs_r};
      end
      gcfo_pkg::MUL_AX: begin
        opa = {1'b0, ax_r};
        opb = {1'b0, ax_r};
      end
      gcfo_pkg::MUL_AZ: begin
        opa = {1'b0, az_r};
        opb = {1'b0, az_r};
      end
      gcfo_pkg::MUL_RD: begin
        opa = {{(MulW-gcfo_pkg::RdW){1'b0}}, rd_r};
        opb = {{(MulW-gcfo_pkg::RdW){1'b0}}, rd_r};
      end
      default: begin
      end
    endcase
    prod = opa * opb;
  end

  // Rebase decision: exact squared distance against the squared threshold.
  logic [64:0] sq_sum;
  logic        far, do_rebase;

  always_comb begin
    sq_sum    = {1'b0, sqx_r} + {1'b0, sqz_r};
    far       = big_r || (sq_sum >= {3'b000, thr2_r});
    do_rebase = (cmd_r == gcfo_pkg::CmdFocus) && !outside_r && far;
  end

  // Divider lane results after one step.
  logic [CsW+PosW-1:0] step_x, step_z;

  always_comb begin
    step_x = div_step(dvd_x_r, rem_x_r, cs_r);
    step_z = div_step(dvd_z_r, rem_z_r, cs_r);
  end

  // Working registers, one group per command.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r     <= in_data.cmd;
      pos_y_r   <= py_u;
      cs_r      <= cs_eff;
      rd_r      <= rd_eff;
      outside_r <= (magx > {1'b0, he_eff}) || (magz > {1'b0, he_eff});
      neg_x_r   <= px_u[PosW-1];
      neg_z_r   <= pz_u[PosW-1];
      dvd_x_r   <= magx;
      dvd_z_r   <= magz;
      rem_x_r   <= '0;
      rem_z_r   <= '0;
      local_x_r <= sat_diff(dx);
      local_y_r <= sat_diff(dy);
      local_z_r <= sat_diff(dz);
      ax_r      <= adx[31:0];
      az_r      <= adz[31:0];
      big_r     <= (|adx[PosW:32]) || (|adz[PosW:32]);
    end
    if (cmd.div_step) begin
      {rem_x_r, dvd_x_r} <= step_x;
      {rem_z_r, dvd_z_r} <= step_z;
    end
    if (cmd.fix) begin
      cell_x_r <= outside_r ? '0 : floor_sat(neg_x_r, dvd_x_r, |rem_x_r);
      cell_z_r <= outside_r ? '0 : floor_sat(neg_z_r, dvd_z_r, |rem_z_r);
    end
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        gcfo_pkg::MUL_CX: corner_x_r <= sat_prod(prod);
        gcfo_pkg::MUL_CZ: corner_z_r <= sat_prod(prod);
        gcfo_pkg::MUL_AX: sqx_r      <= prod[63:0];
        gcfo_pkg::MUL_AZ: sqz_r      <= prod[63:0];
        gcfo_pkg::MUL_RD: thr2_r     <= prod[61:0];
        default: begin
        end
      endcase
    end
  end

  // Origin update on commit of a focus item that rebases.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      origin_z_r <= '0;
    end else if (cmd.commit && do_rebase) begin
      origin_x_r <= corner_x_r;
      origin_y_r <= pos_y_r;
      origin_z_r <= corner_z_r;
    end
  end

  // Output register, loaded on commit.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r.cell_x       <= cell_x_r;
      out_r.cell_z       <= cell_z_r;
      out_r.outside      <= outside_r;
      out_r.corner_x     <= corner_x_r;
      out_r.corner_z     <= corner_z_r;
      out_r.local_x      <= local_x_r;
      out_r.local_y      <= local_y_r;
      out_r.local_z      <= local_z_r;
      out_r.rebased      <= do_rebase;
      out_r.origin_out_x <= do_rebase ? corner_x_r : origin_x_r;
      out_r.origin_out_y <= do_rebase ? pos_y_r    : origin_y_r;
      out_r.origin_out_z <= do_rebase ? corner_z_r : origin_z_r;
    end
  end

  assign out_data = out_r;

endmodule

// File: rtl/grid_cell_and_floating_origin_top.sv
// Floating-origin grid partition: one result per item. The block takes no new
// item until it has committed the result of the last one.
// Each item passes through a load, the 40-step bit-serial floor divider, a floor
// fix, five passes through the shared multiplier and a commit, which waits while
// the output register is full and stalled.
// Synchronous reset clears the origin, restores the register defaults and
// empties the output register.
module grid_cell_and_floating_origin_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  gcfo_pkg::gcfo_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output gcfo_pkg::gcfo_out_t           out_data,
  input  logic                          cfg_we,
  input  logic [gcfo_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [gcfo_pkg::CfgW-1:0]     cfg_wdata
);

  gcfo_pkg::dp_cmd_t cmd;

  // Sequencing of one item.
  gcfo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Arithmetic, configuration and origin state.
  gcfo_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

  // A commit always leaves a result waiting.
  a_commit_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("commit did not produce a valid result");

  // After an input transfer the block is busy with that item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again before the item finished");

  // At most one datapath command is active per cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.div_step, cmd.fix, cmd.mul_en, cmd.commit}))
    else $error("overlapping datapath commands");

  // A rebase only happens inside the extent and moves the origin to the corner.
  a_rebase_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.rebased) |->
      (!out_data.outside && out_data.origin_out_x == out_data.corner_x &&
       out_data.origin_out_z == out_data.corner_z))
    else $error("rebase result inconsistent with the cell corner");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for grid_cell_and_floating_origin_top.
// Depends on gcfo_pkg for the item structs, command codes and register indexes.
module tb;
  import gcfo_pkg::*;

  localparam longint Q40Max = 64'sd549755813887;
  localparam longint Q40Min = -64'sd549755813888;
  localparam longint Cell32Max = 64'sd2147483647;
  localparam longint Cell32Min = -64'sd2147483648;
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;
  localparam int WatchdogLimit = 4000;
  localparam int ItemsPerPhase = 69;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  gcfo_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  gcfo_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_wdata = '0;

  // Register and origin copies kept by the predictor.
  logic [CsW-1:0] cell_size_m = CellSizeDefault;
  logic [HeW-1:0] half_extent_m = HalfExtDefault;
  logic [RdW-1:0] rebase_dist_m = RebaseDefault;
  longint org_x = 0;
  longint org_y = 0;
  longint org_z = 0;

  gcfo_in_t pending_q[$];
  gcfo_out_t expected_q[$];
  int items_queued = 0;
  int results_seen = 0;
  int sent_count = 0;
  int mismatches = 0;
  int gap_left = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  bit steady = 1'b0;
  bit draining = 1'b0;

  grid_cell_and_floating_origin_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint clamp40(longint v);
    if (v > Q40Max) return Q40Max;
    if (v < Q40Min) return Q40Min;
    return v;
  endfunction

  // Floor division, then clamp to the 32-bit cell range.
  function automatic longint floor_cell(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q = q - 1;
    if (q > Cell32Max) q = Cell32Max;
    if (q < Cell32Min) q = Cell32Min;
    return q;
  endfunction

  // Expected result of one item; moves the origin copy when a focus rebases.
  function automatic gcfo_out_t locate_and_rebase(input gcfo_in_t it);
    longint px, py, pz, cs, he, rd, cx, cz, kx, kz, lx, ly, lz;
    logic [83:0] ax, az, thr;
    logic off_grid, moved;
    gcfo_out_t r;
    px = it.pos_x;
    py = it.pos_y;
    pz = it.pos_z;
    cs = cell_size_m;
    if (cs == 0) cs = CellSizeDefault;
    he = half_extent_m;
    if (he == 0) he = HalfExtDefault;
    rd = rebase_dist_m;
    if (rd == 0) rd = RebaseDefault;
    off_grid = (magnitude(px) > he) || (magnitude(pz) > he);
    cx = 0;
    cz = 0;
    kx = 0;
    kz = 0;
    if (!off_grid) begin
      cx = floor_cell(px, cs);
      cz = floor_cell(pz, cs);
      kx = clamp40(cx * cs);
      kz = clamp40(cz * cs);
    end
    lx = clamp40(px - org_x);
    ly = clamp40(py - org_y);
    lz = clamp40(pz - org_z);
    r = '0;
    r.cell_x = cx[CellW-1:0];
    r.cell_z = cz[CellW-1:0];
    r.outside = off_grid;
    r.corner_x = kx[PosW-1:0];
    r.corner_z = kz[PosW-1:0];
    r.local_x = lx[PosW-1:0];
    r.local_y = ly[PosW-1:0];
    r.local_z = lz[PosW-1:0];
    // Exact squared-distance test, wide enough that nothing overflows.
    ax = magnitude(px - org_x);
    az = magnitude(pz - org_z);
    thr = rd;
    moved = (it.cmd == CmdFocus) && !off_grid && (ax * ax + az * az >= thr * thr);
    if (moved) begin
      org_x = kx;
      org_y = py;
      org_z = kz;
    end
    r.rebased = moved;
    r.origin_out_x = org_x[PosW-1:0];
    r.origin_out_y = org_y[PosW-1:0];
    r.origin_out_z = org_z[PosW-1:0];
    return r;
  endfunction

  function automatic logic [PosW-1:0] rand40();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[PosW-1:0];
  endfunction

  // Idle length: mostly none, sometimes short, rarely long.
  function automatic int pick_pause(int short_pct, int long_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < long_pct) return $urandom_range(20, 90);
    if (r < long_pct + short_pct) return $urandom_range(1, 4);
    return 0;
  endfunction

  // A coordinate biased toward the extent, cell edges and field limits.
  function automatic longint pick_coord(longint he, longint cs);
    int unsigned r;
    logic signed [PosW-1:0] s;
    logic [63:0] w;
    longint k;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      s = rand40();
      return s;
    end
    if (r < 20) begin
      case ($urandom_range(0, 7))
        0: return Q40Min;
        1: return Q40Max;
        2: return 0;
        3: return -1;
        4: return he;
        5: return -he;
        6: return clamp40(he + 1);
        default: return -he - 1;
      endcase
    end
    if (r < 35) begin
      k = longint'($urandom_range(0, 4000)) - 2000;
      return clamp40(k * cs + longint'($urandom_range(0, 2)) - 1);
    end
    w = {$urandom(), $urandom()};
    return longint'(w % (2 * he + 1)) - he;
  endfunction

  task automatic send_item(logic cmd, longint x, longint y, longint z);
    gcfo_in_t it;
    it.cmd = cmd;
    it.pos_x = x[PosW-1:0];
    it.pos_y = y[PosW-1:0];
    it.pos_z = z[PosW-1:0];
    pending_q.push_back(it);
    items_queued++;
  endtask

  task automatic send_random();
    longint he, cs, y;
    logic signed [PosW-1:0] s;
    logic cmd;
    he = half_extent_m;
    if (he == 0) he = HalfExtDefault;
    cs = cell_size_m;
    if (cs == 0) cs = CellSizeDefault;
    cmd = ($urandom_range(0, 99) < 45) ? CmdFocus : CmdLocate;
    if ($urandom_range(0, 1) == 1) begin
      s = rand40();
      y = s;
    end else begin
      y = longint'($urandom_range(0, 2000000)) - 1000000;
    end
    send_item(cmd, pick_coord(he, cs), y, pick_coord(he, cs));
  endtask

  // Waits until every queued item has produced its result.
  task automatic wait_quiet();
    while (results_seen < items_queued) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CfgW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgCellSize:   cell_size_m = value[CsW-1:0];
      CfgHalfExtent: half_extent_m = value[HeW-1:0];
      CfgRebaseDist: rebase_dist_m = value[RdW-1:0];
      default: ;
    endcase
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Input driver: presents queued items, with random gaps and drain pauses.
  always @(posedge clk) begin : item_driver
    logic busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        expected_q.push_back(locate_and_rebase(in_data));
        sent_count++;
        busy = 1'b0;
        if (sent_count % 90 == 45) draining = 1'b1;
        if (!steady) gap_left = pick_pause(35, 5);
      end
      if (draining && expected_q.size() == 0) draining = 1'b0;
      if (!busy) begin
        if (gap_left > 0 || draining || pending_q.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          in_data <= pending_q.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Result monitor: checks each transfer against the oldest expectation.
  always @(posedge clk) begin : result_monitor
    gcfo_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("result transfer with no expected result pending");
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_field("cell_x", want.cell_x, out_data.cell_x);
          check_field("cell_z", want.cell_z, out_data.cell_z);
          check_field("outside", want.outside, out_data.outside);
          check_field("corner_x", want.corner_x, out_data.corner_x);
          check_field("corner_z", want.corner_z, out_data.corner_z);
          check_field("local_x", want.local_x, out_data.local_x);
          check_field("local_y", want.local_y, out_data.local_y);
          check_field("local_z", want.local_z, out_data.local_z);
          check_field("rebased", want.rebased, out_data.rebased);
          check_field("origin_out_x", want.origin_out_x, out_data.origin_out_x);
          check_field("origin_out_y", want.origin_out_y, out_data.origin_out_y);
          check_field("origin_out_z", want.origin_out_z, out_data.origin_out_z);
        end
      end
      if (stall_left == 0 && !steady) stall_left = pick_pause(10, 1);
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("FAIL grid_cell_and_floating_origin_top");
        $finish;
      end
    end
  end

  initial begin : stimulus
    longint bx, bz;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset registers: extent and distance boundaries, saturation of local.
    send_item(CmdLocate, 0, 0, 0);
    send_item(CmdLocate, Q40Max, Q40Max, Q40Max);
    send_item(CmdLocate, Q40Min, Q40Min, Q40Min);
    send_item(CmdLocate, 512000, -1, -512000);
    send_item(CmdLocate, 512001, 0, 0);
    send_item(CmdLocate, 0, 0, -512001);
    send_item(CmdFocus, 131071, 5, 0);
    send_item(CmdFocus, 512001, 0, 0);
    send_item(CmdFocus, 131072, 77, 0);
    send_item(CmdLocate, -512000, Q40Min, 512000);
    send_item(CmdFocus, -512000, -1000, -512000);
    send_item(CmdLocate, Q40Max, Q40Max, Q40Min);
    send_item(CmdLocate, -1, 123, -32768);
    wait_quiet();

    // Unit cells and the widest extent: quotients saturate to 32 bits.
    write_reg(CfgCellSize, 1);
    write_reg(CfgHalfExtent, 64'd549755813887);
    write_reg(CfgRebaseDist, 100000);
    write_reg(CfgSpare, 64'h7F_FFFF_FFFF);
    send_item(CmdLocate, Q40Max, 0, Q40Min + 1);
    // A 3-4-5 offset lands just short of and then exactly on the threshold.
    bx = org_x;
    bz = org_z;
    send_item(CmdFocus, bx + 59999, 9, bz + 80000);
    send_item(CmdFocus, bx + 60000, 11, bz + 80000);
    wait_quiet();

    // Large odd cell size: the corner of the lowest cell saturates to 40 bits.
    write_reg(CfgCellSize, 16777215);
    send_item(CmdLocate, Q40Min + 1, 0, Q40Max);
    send_item(CmdFocus, Q40Min + 1, -3, Q40Min + 1);
    wait_quiet();

    // Random phases, each under its own register setting.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          write_reg(CfgCellSize, 0);
          write_reg(CfgHalfExtent, 0);
          write_reg(CfgRebaseDist, 0);
        end
        1: begin
          write_reg(CfgCellSize, 1);
          write_reg(CfgHalfExtent, 1000);
          write_reg(CfgRebaseDist, 1);
        end
        2: begin
          write_reg(CfgCellSize, 16777216);
          write_reg(CfgHalfExtent, 64'd549755813887);
          write_reg(CfgRebaseDist, 2147483647);
        end
        3: begin
          write_reg(CfgCellSize, $urandom_range(1, 4096));
          write_reg(CfgHalfExtent, {$urandom(), $urandom()} & 64'h7F_FFFF_FFFF | 64'd1);
          write_reg(CfgRebaseDist, $urandom() & 32'h7FFF_FFFF | 32'd1);
        end
        4: begin
          write_reg(CfgCellSize, 256);
          write_reg(CfgHalfExtent, 64'd1 << 20);
          write_reg(CfgRebaseDist, 5000);
        end
        5: begin
          write_reg(CfgCellSize, $urandom_range(1, 16777216));
          write_reg(CfgHalfExtent, $urandom_range(1, 1 << 24));
          write_reg(CfgRebaseDist, 1);
        end
        6: begin
          write_reg(CfgCellSize, 3);
          write_reg(CfgHalfExtent, 64'd549755813887);
          write_reg(CfgRebaseDist, $urandom_range(1, 1 << 20));
        end
        default: begin
          write_reg(CfgCellSize, 32768);
          write_reg(CfgHalfExtent, 512000);
          write_reg(CfgRebaseDist, 131072);
        end
      endcase
      // Two phases run with no random gaps or stalls; drain pauses still apply.
      steady = (p == 2 || p == 6);
      for (int i = 0; i < ItemsPerPhase; i++) send_random();
      wait_quiet();
      steady = 1'b0;
    end

    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("PASS grid_cell_and_floating_origin_top");
    end else begin
      $display("FAIL grid_cell_and_floating_origin_top");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/gcfo_pkg.sv
rtl/gcfo_ctrl.sv
rtl/gcfo_dpath.sv
rtl/grid_cell_and_floating_origin_top.sv
tb/sv/tb.sv
